// ===== hw/rtl/btc_pkg.sv =====
// Shared types, constants and helpers for the BCD timestamp check and decode block.
package btc_pkg;

    // One timestamp as read from the clock chip, packed BCD, high digit in bits 7..4.
    typedef struct packed {
        logic [7:0] seconds_bcd;
        logic [7:0] minutes_bcd;
        logic [7:0] hours_bcd;
        logic [7:0] day_bcd;
        logic [7:0] month_bcd;
        logic [7:0] year_bcd;
    } t_stamp_in;

    // Decoded timestamp.
    typedef struct packed {
        logic       stamp_ok;
        logic [5:0] seconds_bin;
        logic [5:0] minutes_bin;
        logic [4:0] hours_bin;
        logic [4:0] day_of_month;
        logic [3:0] month_index;
        logic [7:0] years_since_1900;
    } t_stamp_out;

    // Upper limits, in BCD.
    localparam logic [7:0] MAX_SEC_BCD   = 8'h59;
    localparam logic [7:0] MAX_MIN_BCD   = 8'h59;
    localparam logic [7:0] MAX_HOUR_BCD  = 8'h23;
    localparam logic [7:0] MAX_MONTH_BCD = 8'h12;
    localparam logic [7:0] DAYS_LONG     = 8'h31;
    localparam logic [7:0] DAYS_SHORT    = 8'h30;
    localparam logic [7:0] DAYS_FEB_LEAP = 8'h29;
    localparam logic [7:0] DAYS_FEB      = 8'h28;

    // Month codes, in BCD.
    localparam logic [7:0] MON_JAN = 8'h01;
    localparam logic [7:0] MON_FEB = 8'h02;
    localparam logic [7:0] MON_MAR = 8'h03;
    localparam logic [7:0] MON_MAY = 8'h05;
    localparam logic [7:0] MON_JUL = 8'h07;
    localparam logic [7:0] MON_AUG = 8'h08;
    localparam logic [7:0] MON_OCT = 8'h10;
    localparam logic [7:0] MON_DEC = 8'h12;

    localparam logic [7:0] YEAR_BASE_OFFSET = 8'(2000 - 1900);
    localparam logic [7:0] DEFAULT_YEARS    = 8'(1970 - 1900);
    localparam logic [4:0] DEFAULT_DAY      = 5'd1;

    // Two packed BCD digits to binary; hi*10 as two shifts.
    function automatic logic [6:0] bcd_to_bin(input logic [7:0] v);
        logic [6:0] hi;
        logic [6:0] lo;
        hi = {3'b000, v[7:4]};
        lo = {3'b000, v[3:0]};
        return (hi << 3) + (hi << 1) + lo;
    endfunction

    // Low digit a decimal digit, high digit no larger than hi_max.
    function automatic logic digits_ok(input logic [7:0] v, input logic [3:0] hi_max);
        return (v[3:0] <= 4'd9) && (v[7:4] <= hi_max);
    endfunction

endpackage

// ===== hw/rtl/btc_check.sv =====
// Digit, range and month-length checks for one timestamp.
module btc_check (
    input  btc_pkg::t_stamp_in i_stamp,
    output logic               o_ok
);
    import btc_pkg::*;

    logic [7:0] day_max;
    logic [6:0] year_bin;
    logic       leap;
    logic       date_ok;
    logic       time_ok;

    assign year_bin = bcd_to_bin(i_stamp.year_bcd);
    // Divisible by 4 only; exact within 2000..2099.
    assign leap     = (year_bin[1:0] == 2'b00);

    always_comb begin
        unique case (i_stamp.month_bcd) inside
            MON_FEB: begin
                day_max = leap ? DAYS_FEB_LEAP : DAYS_FEB;
            end
            MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: begin
                day_max = DAYS_LONG;
            end
            default: begin
                day_max = DAYS_SHORT;
            end
        endcase
    end

    assign date_ok = digits_ok(i_stamp.year_bcd, 4'd9)
                  && digits_ok(i_stamp.month_bcd, 4'd1)
                  && (i_stamp.month_bcd != 8'h00)
                  && (i_stamp.month_bcd <= MAX_MONTH_BCD)
                  && digits_ok(i_stamp.day_bcd, 4'd3)
                  && (i_stamp.day_bcd != 8'h00)
                  && (i_stamp.day_bcd <= day_max);

    assign time_ok = digits_ok(i_stamp.hours_bcd, 4'd2)
                  && (i_stamp.hours_bcd <= MAX_HOUR_BCD)
                  && digits_ok(i_stamp.minutes_bcd, 4'd5)
                  && (i_stamp.minutes_bcd <= MAX_MIN_BCD)
                  && digits_ok(i_stamp.seconds_bcd, 4'd5)
                  && (i_stamp.seconds_bcd <= MAX_SEC_BCD);

    assign o_ok = date_ok && time_ok;

endmodule

// ===== hw/rtl/btc_conv.sv =====
// BCD to binary conversion of each field, with the epoch default on a bad stamp.
module btc_conv (
    input  btc_pkg::t_stamp_in  i_stamp,
    input  logic                i_ok,
    output btc_pkg::t_stamp_out o_result
);
    import btc_pkg::*;

    logic [6:0] sec_bin;
    logic [6:0] min_bin;
    logic [6:0] hour_bin;
    logic [6:0] day_bin;
    logic [6:0] mon_bin;
    logic [6:0] year_bin;
    logic [3:0] mon_idx;
    logic [7:0] years;

    assign sec_bin  = bcd_to_bin(i_stamp.seconds_bcd);
    assign min_bin  = bcd_to_bin(i_stamp.minutes_bcd);
    assign hour_bin = bcd_to_bin(i_stamp.hours_bcd);
    assign day_bin  = bcd_to_bin(i_stamp.day_bcd);
    assign mon_bin  = bcd_to_bin(i_stamp.month_bcd);
    assign year_bin = bcd_to_bin(i_stamp.year_bcd);

    assign mon_idx  = mon_bin[3:0] - 4'd1;
    assign years    = {1'b0, year_bin} + YEAR_BASE_OFFSET;

    always_comb begin
        if (i_ok) begin
            o_result.stamp_ok         = 1'b1;
            o_result.seconds_bin      = sec_bin[5:0];
            o_result.minutes_bin      = min_bin[5:0];
            o_result.hours_bin        = hour_bin[4:0];
            o_result.day_of_month     = day_bin[4:0];
            o_result.month_index      = mon_idx;
            o_result.years_since_1900 = years;
        end else begin
            o_result.stamp_ok         = 1'b0;
            o_result.seconds_bin      = 6'd0;
            o_result.minutes_bin      = 6'd0;
            o_result.hours_bin        = 5'd0;
            o_result.day_of_month     = DEFAULT_DAY;
            o_result.month_index      = 4'd0;
            o_result.years_since_1900 = DEFAULT_YEARS;
        end
    end

endmodule

// ===== hw/rtl/bcd_timestamp_check_decode.sv =====
// Top level: registered BCD timestamp check and decode.
//
// Takes one real-time-clock timestamp of six packed BCD bytes per item and
// returns one decoded item: binary seconds, minutes, hours, day, month from 0
// and years since 1900, with stamp_ok high. Any bad digit, out-of-range field
// or day past the end of its month (February leap years taken as year
// divisible by 4, exact for 2000..2099) gives 1970-01-01 00:00:00 with
// stamp_ok low. An item is accepted every cycle while o_stall is low. The
// input register holds the item, the check and conversion logic sits
// between it and the result register, and the result register drives the
// output. The result register only holds while the output side stalls; the
// input register keeps taking items until both registers are full and the
// output side stalls.
module bcd_timestamp_check_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  btc_pkg::t_stamp_in  i_stamp,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output btc_pkg::t_stamp_out o_result
);
    import btc_pkg::*;

    t_stamp_in  r_in;
    logic       r_in_vld;
    logic       n_in_vld;
    t_stamp_out r_out;
    logic       r_out_vld;
    logic       n_out_vld;

    logic       out_load;   // result register free to take the next item
    logic       in_take;    // item accepted on the input channel
    logic       stamp_ok;
    t_stamp_out decoded;

    // Result register moves when empty or its item is being taken.
    assign out_load = !r_out_vld || !i_stall;
    // Stall the input only when both registers are full and the output is stuck.
    assign o_stall  = r_in_vld && !out_load;
    assign in_take  = i_valid && !o_stall;

    // Input register
    always_comb begin
        if (in_take) begin
            n_in_vld = 1'b1;
        end else if (out_load) begin
            n_in_vld = 1'b0;
        end else begin
            n_in_vld = r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= n_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_stamp;
        end
    end

    // Check and decode
    btc_check u_check (
        .i_stamp (r_in),
        .o_ok    (stamp_ok)
    );

    btc_conv u_conv (
        .i_stamp  (r_in),
        .i_ok     (stamp_ok),
        .o_result (decoded)
    );

    // Result register
    assign n_out_vld = out_load ? r_in_vld : r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_in_vld) begin
            r_out <= decoded;
        end
    end

    assign o_valid  = r_out_vld;
    assign o_result = r_out;

    // Assertions
    a_bad_gives_default: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.stamp_ok) |->
            (o_result.seconds_bin == 6'd0) && (o_result.minutes_bin == 6'd0)
            && (o_result.hours_bin == 5'd0) && (o_result.day_of_month == DEFAULT_DAY)
            && (o_result.month_index == 4'd0)
            && (o_result.years_since_1900 == DEFAULT_YEARS))
        else $error("bad stamp result is not the default");

    a_good_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.stamp_ok) |->
            (o_result.month_index <= 4'd11) && (o_result.day_of_month != 5'd0)
            && (o_result.hours_bin <= 5'd23) && (o_result.seconds_bin <= 6'd59)
            && (o_result.years_since_1900 >= YEAR_BASE_OFFSET))
        else $error("good stamp result out of range");

    a_held_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !out_load) |=> (r_in_vld && $stable(r_in)))
        else $error("waiting input item lost or changed");

    a_no_take_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_out_vld && i_stall) |-> !in_take)
        else $error("item taken with both registers full");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !r_in_vld))
        else $error("registers not empty after reset");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the BCD timestamp check and decode block.
`timescale 1ns / 1ps

module tb_top;
    import btc_pkg::*;

    // Lowest legal byte for day and month, highest legal year byte.
    localparam logic [7:0] BCD_ONE  = 8'h01;
    localparam logic [7:0] BCD_ZERO = 8'h00;
    localparam logic [7:0] BCD_TOP  = 8'h99;

    // Ways to build a random stamp.
    typedef enum {
        GEN_GOOD,       // well-formed date and time
        GEN_DAY_EDGE,   // day at or one past the month length
        GEN_ONE_FIELD,  // well-formed, then one byte replaced by noise
        GEN_NOISE       // all six bytes random
    } t_gen_kind;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    t_stamp_in  i_stamp;
    logic       o_valid;
    logic       i_stall;
    t_stamp_out o_result;

    // Decodes predicted for accepted items, oldest first.
    t_stamp_out expected_decodes[$];
    t_stamp_out want_decode;

    int  mismatch_count = 0;
    int  stamps_sent    = 0;
    int  stamps_good    = 0;

    // Idling controls: sender gaps, receiver stalls, and one long hold-off.
    bit  sender_idles   = 1'b1;
    bit  receiver_idles = 1'b1;
    int  hold_cycles    = 0;

    bcd_timestamp_check_decode i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_stamp  (i_stamp),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    // 8 ns clock.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Binary value of two BCD digits, taken at face value.
    function automatic int unsigned pair_value(input logic [7:0] b);
        return int'(b[7:4]) * 10 + int'(b[3:0]);
    endfunction

    // Low digit decimal and whole byte within [lo, hi]; with a decimal low
    // digit this also bounds the high digit.
    function automatic logic bcd_in_range(input logic [7:0] b, input logic [7:0] lo,
                                          input logic [7:0] hi);
        return (b[3:0] <= 4'd9) && (b >= lo) && (b <= hi);
    endfunction

    function automatic t_stamp_out decode_stamp(input t_stamp_in s);
        t_stamp_out  r;
        logic [7:0]  day_limit;
        int unsigned year_val;
        logic        ok;
        year_val = pair_value(s.year_bcd);
        // Month length; leap year is simply year mod 4 (fine for 20xx).
        case (s.month_bcd)
            MON_FEB: begin
                day_limit = (year_val % 4 == 0) ? DAYS_FEB_LEAP : DAYS_FEB;
            end
            MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: begin
                day_limit = DAYS_LONG;
            end
            default: begin
                day_limit = DAYS_SHORT;
            end
        endcase
        ok = bcd_in_range(s.seconds_bcd, BCD_ZERO, MAX_SEC_BCD)
          && bcd_in_range(s.minutes_bcd, BCD_ZERO, MAX_MIN_BCD)
          && bcd_in_range(s.hours_bcd,   BCD_ZERO, MAX_HOUR_BCD)
          && bcd_in_range(s.day_bcd,     BCD_ONE,  day_limit)
          && bcd_in_range(s.month_bcd,   BCD_ONE,  MAX_MONTH_BCD)
          && bcd_in_range(s.year_bcd,    BCD_ZERO, BCD_TOP);
        r = '0;
        if (ok) begin
            r.stamp_ok         = 1'b1;
            r.seconds_bin      = 6'(pair_value(s.seconds_bcd));
            r.minutes_bin      = 6'(pair_value(s.minutes_bcd));
            r.hours_bin        = 5'(pair_value(s.hours_bcd));
            r.day_of_month     = 5'(pair_value(s.day_bcd));
            r.month_index      = 4'(pair_value(s.month_bcd) - 1);
            r.years_since_1900 = 8'(year_val + YEAR_BASE_OFFSET);
        end else begin
            // Rejected stamp decodes to 1970-01-01 00:00:00.
            r.day_of_month     = DEFAULT_DAY;
            r.years_since_1900 = DEFAULT_YEARS;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic logic [7:0] to_bcd(input int unsigned v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    function automatic t_stamp_in random_stamp();
        t_stamp_in   s;
        t_gen_kind   kind;
        int unsigned pick;
        int unsigned yr;
        int unsigned mo;
        int unsigned dy;
        int unsigned len;
        logic [63:0] noise;
        pick = $urandom_range(0, 99);
        kind = (pick < 55) ? GEN_GOOD : (pick < 70) ? GEN_DAY_EDGE :
               (pick < 90) ? GEN_ONE_FIELD : GEN_NOISE;
        yr = $urandom_range(0, 99);
        mo = $urandom_range(1, 12);
        // Day-edge cases lean on February, where the leap rule matters.
        if (kind == GEN_DAY_EDGE && $urandom_range(0, 1) == 0) begin
            mo = 2;
        end
        if (mo == 2) begin
            len = (yr % 4 == 0) ? 29 : 28;
        end else if (mo == 4 || mo == 6 || mo == 9 || mo == 11) begin
            len = 30;
        end else begin
            len = 31;
        end
        dy = (kind == GEN_DAY_EDGE) ? len + $urandom_range(0, 1) : $urandom_range(1, len);
        s.seconds_bcd = to_bcd($urandom_range(0, 59));
        s.minutes_bcd = to_bcd($urandom_range(0, 59));
        s.hours_bcd   = to_bcd($urandom_range(0, 23));
        s.day_bcd     = to_bcd(dy);
        s.month_bcd   = to_bcd(mo);
        s.year_bcd    = to_bcd(yr);
        if (kind == GEN_ONE_FIELD) begin
            case ($urandom_range(0, 5))
                0: s.seconds_bcd = 8'($urandom_range(0, 255));
                1: s.minutes_bcd = 8'($urandom_range(0, 255));
                2: s.hours_bcd   = 8'($urandom_range(0, 255));
                3: s.day_bcd     = 8'($urandom_range(0, 255));
                4: s.month_bcd   = 8'($urandom_range(0, 255));
                default: s.year_bcd = 8'($urandom_range(0, 255));
            endcase
        end else if (kind == GEN_NOISE) begin
            noise = {$urandom(), $urandom()};
            s = noise[47:0];
        end
        return s;
    endfunction

    // Offer one item, optionally after a random gap, and hold it until taken.
    // Stall is sampled on the falling edge, ahead of the accepting edge.
    task automatic send_stamp(input t_stamp_in s);
        int   gap;
        logic taken;
        gap = (sender_idles && $urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_stamp <= s;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end
        expected_decodes.push_back(decode_stamp(s));
        stamps_sent++;
        if (decode_stamp(s).stamp_ok) begin
            stamps_good++;
        end
    endtask

    task automatic send_bcd(input logic [7:0] sec, input logic [7:0] mnt,
                            input logic [7:0] hr, input logic [7:0] dy,
                            input logic [7:0] mo, input logic [7:0] yr);
        t_stamp_in s;
        s.seconds_bcd = sec;
        s.minutes_bcd = mnt;
        s.hours_bcd   = hr;
        s.day_bcd     = dy;
        s.month_bcd   = mo;
        s.year_bcd    = yr;
        send_stamp(s);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, bad digits and out-of-range fields.
    task automatic test_field_extremes();
        send_bcd(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00);  // earliest legal stamp
        send_bcd(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99);  // latest legal stamp
        send_bcd(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);  // all ones
        send_bcd(8'h5A, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00);  // seconds low digit > 9
        send_bcd(8'h60, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00);  // seconds past 59
        send_bcd(8'h00, 8'h60, 8'h00, 8'h01, 8'h01, 8'h00);  // minutes past 59
        send_bcd(8'h00, 8'h00, 8'h24, 8'h01, 8'h01, 8'h00);  // hours past 23
        send_bcd(8'h00, 8'h00, 8'h1A, 8'h01, 8'h01, 8'h00);  // hours low digit > 9
        send_bcd(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00);  // day zero
        send_bcd(8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00);  // month zero
        send_bcd(8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h00);  // month 13
        send_bcd(8'h00, 8'h00, 8'h00, 8'h32, 8'h01, 8'h00);  // day 32
        send_bcd(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'hA0);  // year high digit > 9
        send_bcd(8'h00, 8'h00, 8'h00, 8'h0F, 8'h0A, 8'h9F);  // bad low digits
        send_bcd(8'h37, 8'h48, 8'h19, 8'h15, 8'h07, 8'h42);  // ordinary stamp
    endtask

    // Thirty-day months and February with and without leap year.
    task automatic test_month_lengths();
        send_bcd(8'h00, 8'h00, 8'h12, 8'h31, 8'h04, 8'h25);  // April 31
        send_bcd(8'h00, 8'h00, 8'h12, 8'h30, 8'h04, 8'h25);  // April 30
        send_bcd(8'h00, 8'h00, 8'h12, 8'h31, 8'h06, 8'h25);
        send_bcd(8'h00, 8'h00, 8'h12, 8'h31, 8'h09, 8'h25);
        send_bcd(8'h00, 8'h00, 8'h12, 8'h31, 8'h11, 8'h25);
        send_bcd(8'h00, 8'h00, 8'h12, 8'h29, 8'h02, 8'h24);  // leap year
        send_bcd(8'h00, 8'h00, 8'h12, 8'h29, 8'h02, 8'h23);  // not leap
        send_bcd(8'h00, 8'h00, 8'h12, 8'h28, 8'h02, 8'h23);
        send_bcd(8'h00, 8'h00, 8'h12, 8'h30, 8'h02, 8'h00);  // Feb 30 never legal
        send_bcd(8'h00, 8'h00, 8'h12, 8'h29, 8'h02, 8'h00);  // year 00 is leap here
    endtask

    task automatic test_random_stamps(input int count);
        repeat (count) send_stamp(random_stamp());
    endtask

    // Receiver holds off for a long stretch while items keep coming, so the
    // block fills and pushes back on its input.
    task automatic test_output_backpressure();
        sender_idles = 1'b0;
        hold_cycles  = 250;
        repeat (40) send_stamp(random_stamp());
        sender_idles = 1'b1;
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_full_rate();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        repeat (200) send_stamp(random_stamp());
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Random stall bursts, plus the long hold-off that the backpressure
    // test asks for, counted here in cycles.
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
                i_stall <= 1'b0;
            end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // A result transfers on the next rising edge when valid and not stalled;
    // both are settled by the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_decodes.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with nothing expected, expected none, actual %h",
                         $time, o_result);
            end else begin
                want_decode = expected_decodes.pop_front();
                check_field("stamp_ok",         want_decode.stamp_ok,     o_result.stamp_ok);
                check_field("seconds_bin",      want_decode.seconds_bin,  o_result.seconds_bin);
                check_field("minutes_bin",      want_decode.minutes_bin,  o_result.minutes_bin);
                check_field("hours_bin",        want_decode.hours_bin,    o_result.hours_bin);
                check_field("day_of_month",     want_decode.day_of_month, o_result.day_of_month);
                check_field("month_index",      want_decode.month_index,  o_result.month_index);
                check_field("years_since_1900", want_decode.years_since_1900,
                            o_result.years_since_1900);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        int waited;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_stamp <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_field_extremes();
        test_month_lengths();
        test_random_stamps(880);
        test_output_backpressure();
        test_full_rate();
        i_valid <= 1'b0;

        // Drain, then wait on to catch any stray result.
        waited = 0;
        while (expected_decodes.size() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (10) @(posedge i_clk);
        if (expected_decodes.size() != 0) begin
            mismatch_count += expected_decodes.size();
            $display("%0t: %0d results never arrived", $time, expected_decodes.size());
        end

        $display("Decoded %0d stamps (%0d legal, %0d rejected): field limits, month lengths,",
                 stamps_sent, stamps_good, stamps_sent - stamps_good);
        $display("random stamps with idling, a long output hold-off and a full-rate stretch.");
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("%0t: timeout", $time);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== bcd_timestamp_check_decode.f =====
hw/rtl/btc_pkg.sv
hw/rtl/btc_check.sv
hw/rtl/btc_conv.sv
hw/rtl/bcd_timestamp_check_decode.sv
sim/tb_top.sv
